@@ design/held_note_priority_stack_top_defines.svh @@
// assertion macros shared by the held-note stack modules
// no dependencies
`ifndef HELD_NOTE_PRIORITY_STACK_TOP_DEFINES_SVH
`define HELD_NOTE_PRIORITY_STACK_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define HNPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// plain invariant checked on every clock edge outside reset
`define HNPS_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`endif

@@ design/hnps_pkg.sv @@
// shared types and constants for the held-note stack
// no dependencies
package hnps_pkg;

  localparam int unsigned StackDepth = 8;
  localparam int unsigned PoolSize   = StackDepth + 1;
  localparam int unsigned SlotW      = $clog2(PoolSize);
  localparam int unsigned CountW     = $clog2(StackDepth + 1);
  localparam int unsigned NoteW      = 7;

  typedef logic [SlotW-1:0]  slot_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [NoteW-1:0]  note_t;

  localparam logic [1:0] CmdOn    = 2'd0;
  localparam logic [1:0] CmdOff   = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;
  localparam logic [1:0] CmdNone  = 2'd3;  // unused code, reports only

  // datapath operations
  typedef enum logic [2:0] {
    OpNone    = 3'd0,
    OpClear   = 3'd1,
    OpFindSt  = 3'd2,  // start walk for a note
    OpFindStp = 3'd3,  // one list step
    OpUnlink  = 3'd4,  // unlink found slot, mark pitch removal start
    OpShiftDn = 3'd5,  // one pitch array shift left step
    OpInsert  = 3'd6,  // link free slot at head, start pitch insert
    OpShiftUp = 3'd7   // one pitch insert step
  } op_e;

  typedef struct packed {
    op_e   op;
    note_t note;
    note_t vel;
  } cmd_t;

  typedef struct packed {
    logic   walk_done;  // list walk ended
    logic   found;      // note located at walk_done
    logic   shift_done; // pitch array operation finished
    count_t count;
    note_t  tail_note;
    logic   has_free;
  } status_t;

endpackage

@@ design/hnps_datapath.sv @@
// slot pool, recency list and pitch array with one-step operations
// depends on hnps_pkg and the defines header
`include "held_note_priority_stack_top_defines.svh"
module hnps_datapath
  import hnps_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  output status_t status_o,
  output count_t  held_count_o,
  output note_t   newest_note_o,
  output note_t   newest_velocity_o,
  output note_t   lowest_note_o,
  output note_t   highest_note_o
);

  note_t  note_q [PoolSize];
  note_t  vel_q  [PoolSize];
  slot_t  next_q [PoolSize];
  slot_t  pord_q [PoolSize];
  slot_t  head_q, cur_q, prev_q;
  count_t count_q, idx_q;
  logic [SlotW:0] steps_q;
  logic   done_q, found_q;

  // combinational views
  note_t  tail_note;
  slot_t  open_slot;
  logic   walk_end, walk_hit;
  slot_t  ins_left;

  always_comb begin
    tail_note = '0;
    open_slot = '0;
    for (int i = 1; i < PoolSize; i++) begin
      if (note_q[i] != '0 && next_q[i] == '0) tail_note = note_q[i];
      if (note_q[i] == '0) open_slot = slot_t'(i);
    end
  end

  assign walk_hit = (cur_q != '0) && (note_q[cur_q] == cmd_i.note);
  assign walk_end = (cur_q == '0) || walk_hit || (steps_q >= (SlotW+1)'(StackDepth));
  assign ins_left = (idx_q == '0) ? '0 : pord_q[idx_q - count_t'(1)];

  // one operation per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PoolSize; i++) begin
        note_q[i] <= '0;
        vel_q[i]  <= '0;
        next_q[i] <= '0;
        pord_q[i] <= '0;
      end
      head_q  <= '0;
      cur_q   <= '0;
      prev_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      steps_q <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OpClear: begin
          for (int i = 0; i < PoolSize; i++) begin
            note_q[i] <= '0;
            vel_q[i]  <= '0;
            next_q[i] <= '0;
            pord_q[i] <= '0;
          end
          head_q  <= '0;
          count_q <= '0;
        end
        OpFindSt: begin
          cur_q   <= head_q;
          prev_q  <= '0;
          steps_q <= '0;
          done_q  <= 1'b0;
          found_q <= 1'b0;
        end
        OpFindStp: begin
          if (cmd_i.note == '0) begin
            done_q <= 1'b1;
          end else if (walk_end) begin
            done_q  <= 1'b1;
            found_q <= walk_hit;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= next_q[cur_q];
            steps_q <= steps_q + 1'b1;
          end
        end
        OpUnlink: begin
          if (prev_q != '0) next_q[prev_q] <= next_q[cur_q];
          else head_q <= next_q[cur_q];
          next_q[cur_q] <= '0;
          note_q[cur_q] <= '0;
          vel_q[cur_q]  <= '0;
          idx_q   <= '0;
          found_q <= 1'b0;
          done_q  <= 1'b0;
        end
        OpShiftDn: begin
          // locate cur then pull later entries down one per cycle
          if (idx_q >= count_q) begin
            done_q <= 1'b1;
            if (count_q != '0) count_q <= count_q - 1'b1;
          end else begin
            if (found_q || pord_q[idx_q] == cur_q) begin
              found_q <= 1'b1;
              if (idx_q + 1'b1 < count_q) pord_q[idx_q] <= pord_q[idx_q + 1'b1];
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        OpInsert: begin
          next_q[open_slot] <= head_q;
          note_q[open_slot] <= cmd_i.note;
          vel_q[open_slot]  <= cmd_i.vel;
          head_q <= open_slot;
          cur_q  <= open_slot;
          idx_q  <= count_q;
          done_q <= 1'b0;
        end
        OpShiftUp: begin
          // walk from the top, moving higher notes up
          if (idx_q != '0 && note_q[ins_left] > cmd_i.note) begin
            pord_q[idx_q] <= ins_left;
            idx_q <= idx_q - 1'b1;
          end else begin
            pord_q[idx_q] <= cur_q;
            count_q <= count_q + 1'b1;
            done_q  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign status_o.walk_done  = done_q;
  assign status_o.found      = found_q;
  assign status_o.shift_done = done_q;
  assign status_o.count      = count_q;
  assign status_o.tail_note  = tail_note;
  assign status_o.has_free   = (open_slot != '0);

  assign held_count_o      = count_q;
  assign newest_note_o     = note_q[head_q];
  assign newest_velocity_o = vel_q[head_q];
  assign lowest_note_o     = (count_q == '0) ? '0 : note_q[pord_q[0]];
  assign highest_note_o    = (count_q == '0) ? '0 : note_q[pord_q[count_q - 1'b1]];

  `HNPS_ASSERT(a_count_range, count_q <= count_t'(StackDepth), "held count over depth")
  `HNPS_ASSERT(a_sentinel, note_q[0] == '0, "slot zero holds a note")
  `HNPS_ASSERT_IMP(a_insert_free, cmd_i.op == OpInsert, open_slot != '0, "insert into full pool")

endmodule

@@ design/hnps_ctrl.sv @@
// sequencer for note on, note off and clear
// depends on hnps_pkg and the defines header
`include "held_note_priority_stack_top_defines.svh"
module hnps_ctrl
  import hnps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_cmd_i,
  input  note_t      in_note_i,
  input  note_t      in_vel_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cmd_t       cmd_o,
  input  status_t    status_i
);

  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StFind   = 10'b0000000010,
    StWalk   = 10'b0000000100,
    StUnlink = 10'b0000001000,
    StShDn   = 10'b0000010000,
    StEvict  = 10'b0000100000,
    StInsert = 10'b0001000000,
    StShUp   = 10'b0010000000,
    StDone   = 10'b0100000000,
    StOut    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] cmd_q;
  note_t note_q, vel_q, key_q, key_d;
  logic evict_q, evict_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  // capture item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q  <= CmdOn;
      note_q <= '0;
      vel_q  <= '0;
    end else if (in_valid_i && in_ready_o) begin
      cmd_q  <= in_cmd_i;
      note_q <= in_note_i;
      vel_q  <= in_vel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      key_q   <= '0;
      evict_q <= 1'b0;
    end else begin
      state_q <= state_d;
      key_q   <= key_d;
      evict_q <= evict_d;
    end
  end

  // next state and command
  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    evict_d = evict_q;
    cmd_o.op   = OpNone;
    cmd_o.note = key_q;
    cmd_o.vel  = vel_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          key_d   = in_note_i;
          evict_d = 1'b0;
          if (in_cmd_i == CmdClear) state_d = StDone;
          else if ((in_cmd_i == CmdOn || in_cmd_i == CmdOff) && in_note_i != '0)
            state_d = StFind;
          else state_d = StOut;
        end
      end
      StFind: begin
        if (cmd_q == CmdClear) cmd_o.op = OpClear;
        else cmd_o.op = OpFindSt;
        state_d = (cmd_q == CmdClear) ? StOut : StWalk;
      end
      StWalk: begin
        if (status_i.walk_done) begin
          if (status_i.found) state_d = StUnlink;
          else state_d = StEvict;
        end else cmd_o.op = OpFindStp;
      end
      StUnlink: begin
        cmd_o.op = OpUnlink;
        state_d  = StShDn;
      end
      StShDn: begin
        if (status_i.shift_done) state_d = StEvict;
        else cmd_o.op = OpShiftDn;
      end
      StEvict: begin
        if (cmd_q != CmdOn) state_d = StOut;
        else if (!evict_q && status_i.count >= count_t'(StackDepth)) begin
          evict_d = 1'b1;
          key_d   = status_i.tail_note;
          state_d = StFind;
        end else if (status_i.has_free && status_i.count < count_t'(StackDepth)) begin
          key_d   = note_q;
          state_d = StInsert;
        end else state_d = StOut;
      end
      StInsert: begin
        cmd_o.op = OpInsert;
        state_d  = StShUp;
      end
      StShUp: begin
        if (status_i.shift_done) state_d = StOut;
        else cmd_o.op = OpShiftUp;
      end
      StDone: begin
        cmd_o.op = OpClear;
        state_d  = StOut;
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  `HNPS_ASSERT_IMP(a_out_hold, out_valid_o && !out_ready_i, ##1 out_valid_o,
                   "result dropped while stalled")
  `HNPS_ASSERT_IMP(a_no_accept_busy, state_q != StIdle, !in_ready_o, "accept while busy")
  `HNPS_ASSERT_IMP(a_insert_on, state_q == StInsert, cmd_q == CmdOn, "insert without note on")

endmodule

@@ design/held_note_priority_stack_top.sv @@
// held-note stack: one item at a time; the work per item is set by
// list walks (up to 8 steps) and pitch array shifts (up to 9 steps each),
// with a second walk when a full pool evicts its oldest note; result held until taken
// reset (async, active low) empties the pool and returns to idle
// depends on hnps_pkg, hnps_ctrl, hnps_datapath
module held_note_priority_stack_top
  import hnps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // cmd[1:0], note_number[8:2], note_velocity[15:9]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // held_count, newest_note, newest_velocity,
                                     // lowest_note, highest_note
);

  cmd_t    cmd;
  status_t status;
  count_t  cnt;
  note_t   nn, nv, lo, hi;

  hnps_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tdata[1:0]),
    .in_note_i  (s_axis_tdata[8:2]),
    .in_vel_i   (s_axis_tdata[15:9]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  hnps_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i            (cmd),
    .status_o         (status),
    .held_count_o     (cnt),
    .newest_note_o    (nn),
    .newest_velocity_o(nv),
    .lowest_note_o    (lo),
    .highest_note_o   (hi)
  );

  // result beat
  assign m_axis_tdata = {hi, lo, nv, nn, cnt};

endmodule
